/* src/double_hash_open_address_table_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the double hash open address table
// Shared property forms, used one per line at the end of a module.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_OPEN_ADDRESS_TABLE_ASSERT_SVH
`define DOUBLE_HASH_OPEN_ADDRESS_TABLE_ASSERT_SVH

// same-cycle implication
`define DHOT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DHOT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dhot_pkg.sv */
// ----------------------------------------------------------------------------
// dhot_pkg
// Types, codes and constants shared by the hash table controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhot_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_PROBE_PRIME = 61;
  localparam int DEF_VALUE_BITS  = 32;

  // first-hash and second-hash constants
  localparam int HASH_MOD    = 100000;
  localparam int HASH_DIV_HI = 1000;
  localparam int HASH_DIV_LO = 100;
  localparam int HASH_THRESH = 10000;
  localparam int KEY_MULT    = 1000;

  // divider operand widths: square of letter plus number, largest divisor
  localparam int DIV_DW = 31;
  localparam int DIV_VW = 17;

  localparam int KEY_BITS = 23;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } dhot_op_t;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_PRESENT     = 3'd1,
    ST_FULL        = 3'd2,
    ST_FOUND       = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_DELETED_HIT = 3'd5,
    ST_REMOVED     = 3'd6
  } dhot_status_t;

  typedef enum logic [1:0] {
    DS_MOD,
    DS_DIGIT,
    DS_CAP,
    DS_PRIME
  } dhot_div_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SQUARE,
    S_HMOD_GO,
    S_HMOD_WAIT,
    S_HDIG_GO,
    S_HDIG_WAIT,
    S_HCAP_GO,
    S_HCAP_WAIT,
    S_H2_GO,
    S_H2_WAIT,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_FINISH
  } dhot_state_t;

  typedef struct packed {
    logic          clear_wr;
    logic          load;
    logic          square;
    logic          div_start;
    dhot_div_sel_t div_sel;
    logic          probe_rd;
    logic          probe_chk;
    logic          finish;
  } dhot_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic cmd_valid;
    logic div_done;
    logic probe_end;
  } dhot_stat_t;

endpackage

/* src/dhot_div.sv */
// ----------------------------------------------------------------------------
// dhot_div
// Constant-divisor reducer: quotient by reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhot_div #(
  parameter int CAPACITY    = dhot_pkg::DEF_CAPACITY,
  parameter int PROBE_PRIME = dhot_pkg::DEF_PROBE_PRIME
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  dhot_pkg::dhot_div_sel_t       sel,
  input  logic [dhot_pkg::DIV_DW-1:0]   dividend,
  output logic [dhot_pkg::DIV_DW-1:0]   quotient,
  output logic [dhot_pkg::DIV_VW-1:0]   remainder,
  output logic                          done
);

  localparam int DW = dhot_pkg::DIV_DW;
  localparam int VW = dhot_pkg::DIV_VW;

  // dividend bits per step: square, scaled digits (up to 100000), up to 100, key mix
  localparam int MOD_N = DW;
  localparam int DIG_N = 17;
  localparam int CAP_N = 7;
  localparam int PRM_N = 19;

  localparam int MOD_S = MOD_N + $clog2(dhot_pkg::HASH_MOD);
  localparam int DIG_S = DIG_N + $clog2(dhot_pkg::HASH_DIV_HI);
  localparam int CAP_S = CAP_N + $clog2(CAPACITY);
  localparam int PRM_S = PRM_N + $clog2(PROBE_PRIME);

  // rounded-up reciprocals, exact for every dividend below 2^N
  localparam longint MOD_M = ((longint'(1) << MOD_S) + dhot_pkg::HASH_MOD - 1) /
                             dhot_pkg::HASH_MOD;
  localparam longint DIG_M = ((longint'(1) << DIG_S) + dhot_pkg::HASH_DIV_HI - 1) /
                             dhot_pkg::HASH_DIV_HI;
  localparam longint CAP_M = ((longint'(1) << CAP_S) + CAPACITY - 1) / CAPACITY;
  localparam longint PRM_M = ((longint'(1) << PRM_S) + PROBE_PRIME - 1) / PROBE_PRIME;

  logic [DW-1:0]           x_r;
  dhot_pkg::dhot_div_sel_t sel_r;
  logic [DW-1:0]           quo_r, quo_nxt;
  logic [VW-1:0]           rem_r, rem_nxt;
  logic                    mul_r, sub_r, done_r;
  logic [31:0]             m_sel;
  logic [VW-1:0]           d_sel;
  logic [63:0]             prod;
  logic [DW-1:0]           back;

  always_comb begin
    case (sel_r)
      dhot_pkg::DS_MOD: begin
        m_sel = 32'(MOD_M);
        d_sel = VW'(dhot_pkg::HASH_MOD);
      end
      dhot_pkg::DS_DIGIT: begin
        m_sel = 32'(DIG_M);
        d_sel = VW'(dhot_pkg::HASH_DIV_HI);
      end
      dhot_pkg::DS_CAP: begin
        m_sel = 32'(CAP_M);
        d_sel = VW'(CAPACITY);
      end
      default: begin
        m_sel = 32'(PRM_M);
        d_sel = VW'(PROBE_PRIME);
      end
    endcase
    prod = {33'd0, x_r} * {32'd0, m_sel};
    case (sel_r)
      dhot_pkg::DS_MOD:   quo_nxt = DW'(prod >> MOD_S);
      dhot_pkg::DS_DIGIT: quo_nxt = DW'(prod >> DIG_S);
      dhot_pkg::DS_CAP:   quo_nxt = DW'(prod >> CAP_S);
      default:            quo_nxt = DW'(prod >> PRM_S);
    endcase
    back    = quo_r * {{(DW-VW){1'b0}}, d_sel};
    rem_nxt = VW'(x_r - back);
  end

  // start: hold operand; next cycle: quotient; next: remainder and done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start;
      sub_r  <= mul_r;
      done_r <= sub_r;
    end
    if (start) begin
      x_r   <= dividend;
      sel_r <= sel;
    end
    if (mul_r) quo_r <= quo_nxt;
    if (sub_r) rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

/* src/dhot_ctrl.sv */
// ----------------------------------------------------------------------------
// dhot_ctrl
// Sequencer: clearing pass, hash computation steps, probe loop, finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhot_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dhot_pkg::dhot_stat_t stat,
  output dhot_pkg::dhot_cmd_t  cmd
);

  dhot_pkg::dhot_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhot_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = dhot_pkg::DS_MOD;
    unique case (state_r)
      dhot_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_nxt = dhot_pkg::S_IDLE;
      end
      dhot_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = dhot_pkg::S_SQUARE;
        end
      end
      dhot_pkg::S_SQUARE: begin
        cmd.square = 1'b1;
        // drop straight to the answer for an unused command
        state_nxt = stat.cmd_valid ? dhot_pkg::S_HMOD_GO : dhot_pkg::S_FINISH;
      end
      dhot_pkg::S_HMOD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = dhot_pkg::DS_MOD;
        state_nxt     = dhot_pkg::S_HMOD_WAIT;
      end
      dhot_pkg::S_HMOD_WAIT: begin
        if (stat.div_done) state_nxt = dhot_pkg::S_HDIG_GO;
      end
      dhot_pkg::S_HDIG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = dhot_pkg::DS_DIGIT;
        state_nxt     = dhot_pkg::S_HDIG_WAIT;
      end
      dhot_pkg::S_HDIG_WAIT: begin
        if (stat.div_done) state_nxt = dhot_pkg::S_HCAP_GO;
      end
      dhot_pkg::S_HCAP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = dhot_pkg::DS_CAP;
        state_nxt     = dhot_pkg::S_HCAP_WAIT;
      end
      dhot_pkg::S_HCAP_WAIT: begin
        if (stat.div_done) state_nxt = dhot_pkg::S_H2_GO;
      end
      dhot_pkg::S_H2_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = dhot_pkg::DS_PRIME;
        state_nxt     = dhot_pkg::S_H2_WAIT;
      end
      dhot_pkg::S_H2_WAIT: begin
        if (stat.div_done) state_nxt = dhot_pkg::S_PROBE_RD;
      end
      dhot_pkg::S_PROBE_RD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = dhot_pkg::S_PROBE_CHK;
      end
      dhot_pkg::S_PROBE_CHK: begin
        cmd.probe_chk = 1'b1;
        state_nxt = stat.probe_end ? dhot_pkg::S_FINISH : dhot_pkg::S_PROBE_RD;
      end
      dhot_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = dhot_pkg::S_IDLE;
      end
      default: begin
        state_nxt = dhot_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != dhot_pkg::S_IDLE);

endmodule

/* src/dhot_dp.sv */
// ----------------------------------------------------------------------------
// dhot_dp
// Request registers, hash datapath around a shared reduction unit, slot memory,
// probe walk and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_hash_open_address_table_assert.svh"

module dhot_dp #(
  parameter int CAPACITY    = dhot_pkg::DEF_CAPACITY,
  parameter int PROBE_PRIME = dhot_pkg::DEF_PROBE_PRIME,
  parameter int VALUE_BITS  = dhot_pkg::DEF_VALUE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dhot_pkg::dhot_cmd_t  cmd,
  output dhot_pkg::dhot_stat_t stat,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_key_letter,
  input  logic [14:0]          in_key_number,
  input  logic [31:0]          in_entry_value,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [31:0]          out_found_value,
  output logic [5:0]           out_slot_index
);

  localparam int IW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 2);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int KB = dhot_pkg::KEY_BITS;
  localparam int MW = 2 + KB + VALUE_BITS;
  localparam int DW = dhot_pkg::DIV_DW;
  localparam int VW = dhot_pkg::DIV_VW;

  // request
  logic [1:0]            op_r;
  logic [7:0]            letter_r;
  logic [14:0]           number_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS+31:0] value_ext;

  // hash
  logic [DW-1:0] sq_r;
  logic [VW-1:0] mod_r;
  logic [9:0]    dig_r;
  logic [IW-1:0] h2_r;
  dhot_pkg::dhot_div_sel_t sel_r;

  logic [DW-1:0] div_dividend;
  logic [DW-1:0] div_quo;
  logic [VW-1:0] div_rem;
  logic          div_done;
  logic [15:0]   key_sum;
  logic [18:0]   key_mix;

  // probe
  logic [IW-1:0] idx_r;
  logic [PW-1:0] probe_r;
  logic          have_tomb_r;
  logic [IW-1:0] tomb_r;
  logic          end_empty_r;
  logic          end_hit_r;
  logic [IW:0]   idx_sum;

  // memory
  logic [MW-1:0] mem [CAPACITY];
  logic [MW-1:0] rd_r;
  logic [IW-1:0] clr_r;
  logic          rd_used, rd_live;
  logic [KB-1:0] rd_key;
  logic [VALUE_BITS-1:0] rd_pay;
  logic          chk_empty, chk_hit, chk_last;

  // finish
  logic          we;
  logic [IW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic          fin_wr;
  logic [IW-1:0] fin_addr;
  logic [MW-1:0] fin_data;
  logic [2:0]    fin_status;
  logic [VALUE_BITS-1:0] fin_val;
  logic [IW-1:0] fin_slot;
  logic          fin_inc, fin_dec;
  logic [LW-1:0] live_cnt_r;
  logic [VALUE_BITS+31:0] fval_ext;
  logic [IW+5:0] slot_ext;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [31:0]   out_value_r;
  logic [5:0]    out_slot_r;

  assign value_ext = {{VALUE_BITS{1'b0}}, in_entry_value};
  assign key_sum   = {8'd0, letter_r} + {1'b0, number_r};
  assign key_mix   = {11'd0, letter_r} * 19'(dhot_pkg::KEY_MULT) + {4'd0, number_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_cmd;
      letter_r <= in_key_letter;
      number_r <= in_key_number;
      value_r  <= value_ext[VALUE_BITS-1:0];
    end
    if (cmd.square) sq_r <= {15'd0, key_sum} * {15'd0, key_sum};
  end

  // operand select for the shared reduction unit
  always_comb begin
    case (cmd.div_sel)
      dhot_pkg::DS_MOD: begin
        div_dividend = sq_r;
      end
      dhot_pkg::DS_DIGIT: begin
        // a small square divides by 100: scale by ten and divide by 1000
        if (sq_r > DW'(dhot_pkg::HASH_THRESH)) begin
          div_dividend = DW'(mod_r);
        end else begin
          div_dividend = DW'({sq_r[13:0], 3'b000}) + DW'({sq_r[13:0], 1'b0});
        end
      end
      dhot_pkg::DS_CAP: begin
        div_dividend = DW'(dig_r);
      end
      default: begin
        div_dividend = DW'(key_mix);
      end
    endcase
  end

  dhot_div #(
    .CAPACITY    (CAPACITY),
    .PROBE_PRIME (PROBE_PRIME)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .sel       (cmd.div_sel),
    .dividend  (div_dividend),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // memory word: used, live, key, payload
  assign rd_used = rd_r[MW-1];
  assign rd_live = rd_r[MW-2];
  assign rd_key  = rd_r[VALUE_BITS +: KB];
  assign rd_pay  = rd_r[VALUE_BITS-1:0];

  assign chk_empty = !rd_used;
  assign chk_hit   = rd_used && (rd_key == {letter_r, number_r});
  assign chk_last  = (probe_r == PW'(CAPACITY));
  assign idx_sum   = {1'b0, idx_r} + {1'b0, h2_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) sel_r <= cmd.div_sel;
    if (div_done) begin
      case (sel_r)
        dhot_pkg::DS_MOD:   mod_r <= div_rem;
        dhot_pkg::DS_DIGIT: dig_r <= div_quo[9:0];
        dhot_pkg::DS_CAP:   idx_r <= div_rem[IW-1:0];
        default:            h2_r  <= div_rem[IW-1:0] + 1'b1;
      endcase
    end
    if (cmd.load) begin
      probe_r     <= '0;
      have_tomb_r <= 1'b0;
    end
    if (cmd.probe_chk) begin
      end_empty_r <= chk_empty;
      end_hit_r   <= chk_hit;
      // remember the first tombstone on the path
      if (!chk_empty && !chk_hit && !rd_live && !have_tomb_r) begin
        have_tomb_r <= 1'b1;
        tomb_r      <= idx_r;
      end
      if (!chk_empty && !chk_hit && !chk_last) begin
        probe_r <= probe_r + 1'b1;
        if (idx_sum >= (IW+1)'(CAPACITY)) idx_r <= IW'(idx_sum - (IW+1)'(CAPACITY));
        else                              idx_r <= idx_sum[IW-1:0];
      end
    end
  end

  // finish decision
  always_comb begin
    fin_wr     = 1'b0;
    fin_addr   = idx_r;
    fin_data   = {1'b1, 1'b1, letter_r, number_r, value_r};
    fin_status = dhot_pkg::ST_NOT_FOUND;
    fin_val    = '0;
    fin_slot   = '0;
    fin_inc    = 1'b0;
    fin_dec    = 1'b0;
    case (op_r)
      dhot_pkg::OP_INSERT: begin
        if (end_hit_r && rd_live) begin
          fin_status = dhot_pkg::ST_PRESENT;
          fin_slot   = idx_r;
        end else if (have_tomb_r || end_hit_r || end_empty_r) begin
          fin_wr     = 1'b1;
          fin_addr   = have_tomb_r ? tomb_r : idx_r;
          fin_status = dhot_pkg::ST_INSERTED;
          fin_slot   = fin_addr;
          fin_inc    = 1'b1;
        end else begin
          fin_status = dhot_pkg::ST_FULL;
        end
      end
      dhot_pkg::OP_SEARCH: begin
        if (end_hit_r) begin
          fin_slot = idx_r;
          if (rd_live) begin
            fin_status = dhot_pkg::ST_FOUND;
            fin_val    = rd_pay;
          end else begin
            fin_status = dhot_pkg::ST_DELETED_HIT;
          end
        end
      end
      dhot_pkg::OP_DELETE: begin
        if (end_hit_r) begin
          fin_slot = idx_r;
          if (rd_live) begin
            fin_wr     = 1'b1;
            fin_data   = {1'b1, 1'b0, rd_key, rd_pay};
            fin_status = dhot_pkg::ST_REMOVED;
            fin_dec    = 1'b1;
          end else begin
            fin_status = dhot_pkg::ST_DELETED_HIT;
          end
        end
      end
      default: begin
        fin_status = dhot_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  assign we    = cmd.clear_wr || (cmd.finish && fin_wr);
  assign waddr = cmd.clear_wr ? clr_r : fin_addr;
  assign wdata = cmd.clear_wr ? '0 : fin_data;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.probe_rd) rd_r <= mem[idx_r];
  end

  assign fval_ext = {32'd0, fin_val};
  assign slot_ext = {6'd0, fin_slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      live_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_r <= clr_r + 1'b1;
      out_valid_r <= cmd.finish;
      if (cmd.finish && fin_inc) live_cnt_r <= live_cnt_r + 1'b1;
      if (cmd.finish && fin_dec && (live_cnt_r != '0)) live_cnt_r <= live_cnt_r - 1'b1;
    end
    if (cmd.finish) begin
      out_status_r <= fin_status;
      out_value_r  <= fval_ext[31:0];
      out_slot_r   <= slot_ext[5:0];
    end
  end

  assign stat.clear_last = (clr_r == IW'(CAPACITY - 1));
  assign stat.cmd_valid  = (op_r == dhot_pkg::OP_INSERT) || (op_r == dhot_pkg::OP_SEARCH) ||
                           (op_r == dhot_pkg::OP_DELETE);
  assign stat.div_done   = div_done;
  assign stat.probe_end  = chk_empty || chk_hit || chk_last;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;
  assign out_slot_index  = out_slot_r;

  `DHOT_ASSERT_NOW(a_live_cap, clk, rst_n, 1'b1, live_cnt_r <= LW'(CAPACITY), "live count over capacity")
  `DHOT_ASSERT_NOW(a_step_range, clk, rst_n, cmd.probe_rd, (h2_r != '0) && ({1'b0, h2_r} < (IW+1)'(CAPACITY)), "probe step out of range")
  `DHOT_ASSERT_NOW(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.clear_wr, cmd.load, cmd.probe_rd, cmd.probe_chk, cmd.finish}), "overlapping commands")

endmodule

/* src/double_hash_open_address_table.sv */
// ----------------------------------------------------------------------------
// double_hash_open_address_table
// Open-addressing key/value table with double hashing: insert, search, delete.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -----------------------
//   request   in_cmd in_key_letter in_key_number       start high, busy low
//             in_entry_value
//   result    out_status out_found_value               out_valid, one cycle,
//             out_slot_index                           cannot be held off
//
// Steps: after the accepting edge busy stays high through a square, four hash
//   reductions on a shared reciprocal-multiply unit, a memory read and a check
//   per probe (1 to CAPACITY+1 probes) and a finish; the result strobe comes in
//   the next cycle with busy already low, so a new request can be taken with it.
//   An unused command skips hashing and probing.
// Reset: synchronous, active low. After reset a clearing pass writes every
//   slot with busy high; no request is taken meanwhile.
// Stalls: one request at a time; busy stays high until the result strobe.
//   The receiver cannot stall, so every result is shown exactly once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_hash_open_address_table_assert.svh"

module double_hash_open_address_table #(
  parameter int CAPACITY    = dhot_pkg::DEF_CAPACITY,
  parameter int PROBE_PRIME = dhot_pkg::DEF_PROBE_PRIME,
  parameter int VALUE_BITS  = dhot_pkg::DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_key_letter,
  input  logic [14:0] in_key_number,
  input  logic [31:0] in_entry_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_value,
  output logic [5:0]  out_slot_index
);

  dhot_pkg::dhot_cmd_t  cmd;
  dhot_pkg::dhot_stat_t stat;

  // sequencer: clearing pass, hash steps, probe loop
  dhot_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // hold the request, compute hashes, walk the probe path, answer
  dhot_dp #(
    .CAPACITY    (CAPACITY),
    .PROBE_PRIME (PROBE_PRIME),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_key_letter   (in_key_letter),
    .in_key_number   (in_key_number),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_slot_index  (out_slot_index)
  );

  // an accepted request keeps the block busy until its result
  `DHOT_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "request taken but not busy")
  // the result strobe comes as the block returns to idle
  `DHOT_ASSERT_NOW(a_out_idle, clk, rst_n, out_valid, !busy, "result while still busy")
  // one result per request
  `DHOT_ASSERT_NEXT(a_out_once, clk, rst_n, out_valid, !out_valid, "result repeated")

endmodule

/* tb/sv/double_hash_open_address_table_test.sv */
// ----------------------------------------------------------------------------
// Double hash open address table testbench
// Drives insert, search, delete and unused-command requests, predicts each result with a
// behavioral copy of the table, and compares every result strobe in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_hash_open_address_table_test;

  localparam int CAP        = dhot_pkg::DEF_CAPACITY;
  localparam int PRIME      = dhot_pkg::DEF_PROBE_PRIME;
  localparam int DRAIN_WAIT = 400;
  localparam int DOG_LIMIT  = 20000;
  localparam int RAND_ITEMS = 1800;
  // command code with no operation behind it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] value;
    logic [5:0]  slot;
  } table_answer_t;

  // Behavioral table with its own slot store and an in-order queue of answers.
  class table_scoreboard;
    bit            used [CAP];
    bit            live [CAP];
    bit [22:0]     keys [CAP];
    bit [31:0]     vals [CAP];
    int            live_count;
    table_answer_t pending[$];
    int            mismatches;
    int            checked;

    function new();
      for (int k = 0; k < CAP; k++) begin
        used[k] = 0;
        live[k] = 0;
      end
      live_count = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function int home_slot(bit [7:0] letter, bit [14:0] number);
      longint s;
      longint q;
      s = letter + number;
      q = s * s;
      if (q > 10000) q = (q % 100000) / 1000;
      else q = q / 100;
      return int'(q % CAP);
    endfunction

    function int step_size(bit [7:0] letter, bit [14:0] number);
      return 1 + int'((longint'(letter) * 1000 + number) % PRIME);
    endfunction

    // Note an accepted request: run the probe and queue the expected answer.
    function void note_request(logic [1:0] cmd, bit [7:0] letter, bit [14:0] number,
                               bit [31:0] value);
      bit [22:0]     key;
      int            h1;
      int            h2;
      int            idx;
      int            tomb;
      bit            hit;
      bit            empty;
      bit            have_tomb;
      table_answer_t ans;
      key = {letter, number};
      h1 = home_slot(letter, number);
      h2 = step_size(letter, number);
      hit = 0;
      empty = 0;
      have_tomb = 0;
      tomb = 0;
      idx = 0;
      ans.status = dhot_pkg::ST_NOT_FOUND;
      ans.value = '0;
      ans.slot = '0;
      if (cmd == dhot_pkg::OP_INSERT || cmd == dhot_pkg::OP_SEARCH ||
          cmd == dhot_pkg::OP_DELETE) begin
        for (int i = 0; i <= CAP; i++) begin
          idx = (h1 + i * h2) % CAP;
          if (!used[idx]) begin
            empty = 1;
            break;
          end
          if (keys[idx] == key) begin
            hit = 1;
            break;
          end
          if (!live[idx] && !have_tomb) begin
            have_tomb = 1;
            tomb = idx;
          end
        end
        if (cmd == dhot_pkg::OP_INSERT) begin
          if (hit && live[idx]) begin
            ans.status = dhot_pkg::ST_PRESENT;
            ans.slot = 6'(idx);
          end else begin
            // revive on the matching tombstone unless an earlier one came first
            if (hit && !have_tomb) begin
              have_tomb = 1;
              tomb = idx;
            end
            if (have_tomb || empty) begin
              if (!have_tomb) tomb = idx;
              used[tomb] = 1;
              live[tomb] = 1;
              keys[tomb] = key;
              vals[tomb] = value;
              live_count++;
              ans.status = dhot_pkg::ST_INSERTED;
              ans.slot = 6'(tomb);
            end else begin
              ans.status = dhot_pkg::ST_FULL;
            end
          end
        end else if (hit) begin
          ans.slot = 6'(idx);
          if (!live[idx]) begin
            ans.status = dhot_pkg::ST_DELETED_HIT;
          end else if (cmd == dhot_pkg::OP_SEARCH) begin
            ans.status = dhot_pkg::ST_FOUND;
            ans.value = vals[idx];
          end else begin
            live[idx] = 0;
            if (live_count > 0) live_count--;
            ans.status = dhot_pkg::ST_REMOVED;
          end
        end
      end
      pending.push_back(ans);
    endfunction

    function void check_result(logic [2:0] status, logic [31:0] value, logic [5:0] slot);
      table_answer_t exp_ans;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: status %0d value %h slot %0d",
                   $realtime, status, value, slot);
        return;
      end
      exp_ans = pending.pop_front();
      if (status !== exp_ans.status || value !== exp_ans.value || slot !== exp_ans.slot)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected status %0d value %h slot %0d, got %0d %h %0d",
                   $realtime, exp_ans.status, exp_ans.value, exp_ans.slot,
                   status, value, slot);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [7:0]  in_key_letter;
  logic [14:0] in_key_number;
  logic [31:0] in_entry_value;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_found_value;
  logic [5:0]  out_slot_index;

  table_scoreboard board;
  int              sent;
  int              idle_cycles = 0;
  bit              allow_gaps;
  bit [22:0]       known_keys[$];

  double_hash_open_address_table uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key_letter(in_key_letter), .in_key_number(in_key_number),
    .in_entry_value(in_entry_value), .out_valid(out_valid), .out_status(out_status),
    .out_found_value(out_found_value), .out_slot_index(out_slot_index)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sample at the edge: note accepted requests and check result strobes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_request(in_cmd, in_key_letter, in_key_number, in_entry_value);
        idle_cycles <= 0;
      end else if (out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid) board.check_result(out_status, out_found_value, out_slot_index);
    end
  end

  // Watchdog: long stretches with no handshake at all mean the block hung.
  always @(posedge clk) begin
    if (idle_cycles >= DOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Hold start until the request is taken, then drop it or chain the next one.
  task automatic send_request(logic [1:0] cmd, bit [7:0] letter, bit [14:0] number,
                              bit [31:0] value);
    int gap;
    if (allow_gaps && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_key_letter <= letter;
    in_key_number <= number;
    in_entry_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    release_start();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Keys mostly from a small reused pool so probes collide and revisit entries.
  task automatic random_request(int pool);
    bit [22:0]  key;
    logic [1:0] cmd;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) cmd = dhot_pkg::OP_INSERT;
    else if (pick < 75) cmd = dhot_pkg::OP_SEARCH;
    else if (pick < 97) cmd = dhot_pkg::OP_DELETE;
    else cmd = CMD_UNUSED;
    if (known_keys.size() > 0 && $urandom_range(0, 9) < 7)
      key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    else begin
      key = 23'($urandom);
      if (known_keys.size() < pool) known_keys.push_back(key);
    end
    send_request(cmd, key[22:15], key[14:0], $urandom);
  endtask

  initial begin
    board = new();
    sent = 0;
    allow_gaps = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = dhot_pkg::OP_INSERT;
    in_key_letter = '0;
    in_key_number = '0;
    in_entry_value = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every operation, reuse of tombstones, revive,
    // deleted hits on search and delete, unused command.
    send_request(dhot_pkg::OP_SEARCH, 8'd0, 15'd0, 32'h0);
    send_request(dhot_pkg::OP_INSERT, 8'd0, 15'd0, 32'hFFFF_FFFF);
    send_request(dhot_pkg::OP_INSERT, 8'd0, 15'd0, 32'h1234_5678);
    send_request(dhot_pkg::OP_SEARCH, 8'd0, 15'd0, 32'h0);
    send_request(dhot_pkg::OP_INSERT, 8'hFF, 15'h7FFF, 32'h0);
    send_request(dhot_pkg::OP_INSERT, 8'd10, 15'd90, 32'hA5A5_5A5A);
    send_request(dhot_pkg::OP_INSERT, 8'd0, 15'd100, 32'h5A5A_A5A5);
    send_request(dhot_pkg::OP_SEARCH, 8'hFF, 15'h7FFF, 32'h0);
    send_request(dhot_pkg::OP_DELETE, 8'd0, 15'd0, 32'h0);
    send_request(dhot_pkg::OP_SEARCH, 8'd0, 15'd0, 32'h0);
    send_request(dhot_pkg::OP_DELETE, 8'd0, 15'd0, 32'h0);
    send_request(dhot_pkg::OP_INSERT, 8'd0, 15'd0, 32'hDEAD_BEEF);
    send_request(dhot_pkg::OP_SEARCH, 8'd0, 15'd0, 32'h0);
    send_request(dhot_pkg::OP_DELETE, 8'd10, 15'd90, 32'h0);
    send_request(dhot_pkg::OP_INSERT, 8'd0, 15'd100, 32'h1);
    send_request(dhot_pkg::OP_DELETE, 8'h55, 15'h2AAA, 32'h0);
    send_request(CMD_UNUSED, 8'hFF, 15'h7FFF, 32'hFFFF_FFFF);
    send_request(dhot_pkg::OP_SEARCH, 8'hAA, 15'h5555, 32'h0);

    // Fill the table past capacity to reach the full answer, then probe it.
    for (int k = 0; k < 70; k++)
      send_request(dhot_pkg::OP_INSERT, k[7:0], 15'(k * 37), $urandom);
    for (int k = 0; k < 20; k++)
      send_request(dhot_pkg::OP_SEARCH, k[7:0], 15'(k * 37), 32'h0);
    wait_drained();

    // Random traffic: churn on reused keys with random pacing.
    allow_gaps = 1'b1;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      random_request((k < RAND_ITEMS / 2) ? 40 : 90);
      if (k == RAND_ITEMS / 3) wait_drained();
      if (k == RAND_ITEMS - 300) allow_gaps = 1'b0;
    end
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d requests, %0d results checked, live entries at end %0d",
             sent, board.checked, board.live_count);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("mismatches %0d, still pending %0d", board.mismatches,
               board.pending.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
